FILE: rtl/rct_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the replay clock timestamp unit.
package rct_pkg;

    localparam int NUM_PROCS_DEF   = 16;
    localparam int OFFSET_BITS_DEF = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_OWN_PROCESS = 1'b0;
    localparam logic REG_EPSILON     = 1'b1;

    localparam logic KIND_SEND    = 1'b0;
    localparam logic KIND_RECEIVE = 1'b1;

    localparam logic [3:0] OWN_PROCESS_RESET = 4'd0;
    localparam logic [3:0] EPSILON_RESET     = 4'd15;

    typedef struct packed {
        logic        kind;
        logic [31:0] phys_time;
        logic [31:0] msg_time;
        logic [15:0] msg_valid;
        logic [63:0] msg_offsets;
        logic [31:0] msg_count;
    } in_item_t;

    typedef struct packed {
        logic [31:0] clock_time;
        logic [15:0] clock_valid;
        logic [63:0] clock_offsets;
        logic [31:0] clock_count;
    } out_item_t;

endpackage

FILE: rtl/replay_clock_timestamp_unit_core.sv
`timescale 1ns / 1ps
// Top level of the replay clock timestamp unit: input register, clock update, result register.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   in_data (rct_pkg::in_item_t)
//   out      output     out_valid / out_stall out_data (rct_pkg::out_item_t)
//   config   input      APB psel / penable    own_process at 0x0, epsilon at 0x4
//
// An item is registered on acceptance; the clock state is updated once the output register
// is free, and the result is loaded into the output register together with the new state.
// One item is taken every cycle while the output is not stalled.
// Reset clears the clock state to zero, own_process to 0 and epsilon to 15.
// A stalled output holds its result; the input register keeps accepting until it is full.
module replay_clock_timestamp_unit_core #(
    parameter int NUM_PROCS   = rct_pkg::NUM_PROCS_DEF,
    parameter int OFFSET_BITS = rct_pkg::OFFSET_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rct_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rct_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rct_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  rct_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output rct_pkg::out_item_t             out_data
);
    import rct_pkg::*;

    localparam int PW     = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int OB     = OFFSET_BITS;
    localparam int FULL_W = NUM_PROCS * OB;
    localparam int MO_W   = (FULL_W > 64) ? FULL_W : 64;
    localparam int VM_W   = (NUM_PROCS > 16) ? NUM_PROCS : 16;
    localparam int EW     = (OB > 4) ? OB : 4;
    localparam logic [EW-1:0] OFF_MAX = EW'((1 << OB) - 1);

    logic [3:0]           own_process_reg;
    logic [3:0]           epsilon_reg;
    logic                 in_valid_reg;
    in_item_t             item_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;
    out_item_t            out_next;

    logic [31:0]          time_reg;
    logic [31:0]          time_next;
    logic [NUM_PROCS-1:0] vmap_reg;
    logic [NUM_PROCS-1:0] vmap_next;
    logic [OB-1:0]        off_reg [NUM_PROCS];
    logic [OB-1:0]        off_next [NUM_PROCS];
    logic [31:0]          count_reg;
    logic [31:0]          count_next;

    logic                 cfg_write;
    logic                 out_free;
    logic                 fire;
    logic [3:0]           own_mod;
    logic [PW-1:0]        own_idx;
    logic [EW-1:0]        eps_w;
    logic [OB-1:0]        eps_lim;

    logic [MO_W-1:0]      mo_ext;
    logic [VM_W-1:0]      mv_ext;
    logic [NUM_PROCS-1:0] mv;
    logic [OB-1:0]        mfield [NUM_PROCS];
    logic [31:0]          nt_send;
    logic [31:0]          nt_max;
    logic [31:0]          nt_recv;
    logic [31:0]          nt;
    logic [31:0]          d_loc;
    logic [31:0]          d_msg;
    logic [31:0]          noff;
    logic [31:0]          count_max;
    logic [OB:0]          sh_a [NUM_PROCS];
    logic [OB:0]          sh_b [NUM_PROCS];
    logic [NUM_PROCS-1:0] a_val;
    logic [NUM_PROCS-1:0] b_val;
    logic [NUM_PROCS-1:0] u_val;
    logic [NUM_PROCS-1:0] m_val;
    logic [OB-1:0]        a_off [NUM_PROCS];
    logic [OB-1:0]        b_off [NUM_PROCS];
    logic [OB-1:0]        y_off [NUM_PROCS];
    logic [OB-1:0]        mn_off [NUM_PROCS];
    logic [OB-1:0]        m_off [NUM_PROCS];
    logic                 leq;
    logic                 meq;
    logic [OB-1:0]        own_oo;
    logic                 oo_le;
    logic                 send_same;
    logic [MO_W-1:0]      packed_off;
    logic [VM_W-1:0]      vm_ext;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == '1) ? v : v + 32'd1;
    endfunction

    // Moves one offset forward by a time step; the top bit tells whether it is kept.
    function automatic logic [OB:0] shift_entry(
        input logic          big,
        input logic [OB-1:0] d_lo,
        input logic [OB-1:0] off,
        input logic [OB-1:0] lim
    );
        logic [OB:0] sum;
        sum = {1'b0, d_lo} + {1'b0, off};
        shift_entry = {(!big && (sum < {1'b0, lim})), sum[OB-1:0]};
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[APB_ADDR_W-1])
            REG_OWN_PROCESS: prdata = APB_DATA_W'(own_process_reg);
            REG_EPSILON:     prdata = APB_DATA_W'(epsilon_reg);
            default:         prdata = '0;
        endcase
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        own_mod = own_process_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (int'(own_mod) >= NUM_PROCS)
            begin
                own_mod = own_mod - 4'(NUM_PROCS);
            end
        end
        own_idx = PW'(own_mod);
    end

    assign eps_w   = EW'(epsilon_reg);
    assign eps_lim = OB'((eps_w < OFF_MAX) ? eps_w : OFF_MAX);

    always_comb
    begin
        mo_ext  = MO_W'(item_reg.msg_offsets);
        mv_ext  = VM_W'(item_reg.msg_valid);
        mv      = mv_ext[NUM_PROCS-1:0];
        nt_send = (time_reg > item_reg.phys_time) ? time_reg : item_reg.phys_time;
        nt_max  = (time_reg > item_reg.msg_time) ? time_reg : item_reg.msg_time;
        nt_recv = (item_reg.phys_time > nt_max) ? item_reg.phys_time : nt_max;
        nt      = (item_reg.kind == KIND_RECEIVE) ? nt_recv : nt_send;
        d_loc   = nt - time_reg;
        d_msg   = nt - item_reg.msg_time;
        noff    = nt_send - item_reg.phys_time;

        for (int p = 0; p < NUM_PROCS; p++)
        begin
            mfield[p] = mo_ext[p*OB +: OB];

            sh_a[p]  = shift_entry(|d_loc[31:OB], d_loc[OB-1:0], off_reg[p], eps_lim);
            a_val[p] = vmap_reg[p] ? sh_a[p][OB] : 1'b0;
            a_off[p] = off_reg[p];
            if (vmap_reg[p])
            begin
                a_off[p] = sh_a[p][OB] ? sh_a[p][OB-1:0] : '0;
            end

            b_off[p] = mv[p] ? mfield[p] : '0;
            sh_b[p]  = shift_entry(|d_msg[31:OB], d_msg[OB-1:0], b_off[p], eps_lim);
            b_val[p] = mv[p] ? sh_b[p][OB] : 1'b0;
            if (mv[p])
            begin
                b_off[p] = sh_b[p][OB] ? sh_b[p][OB-1:0] : '0;
            end
        end

        u_val = a_val | b_val;
        for (int p = 0; p < NUM_PROCS; p++)
        begin
            y_off[p]  = b_val[p] ? b_off[p] : eps_lim;
            mn_off[p] = (a_off[p] < y_off[p]) ? a_off[p] : y_off[p];
            m_val[p]  = u_val[p] && (mn_off[p] < eps_lim);
            m_off[p]  = m_val[p] ? mn_off[p] : '0;
        end

        leq = (time_reg == nt) && (vmap_reg == m_val);
        meq = (item_reg.msg_time == nt) && (mv == m_val);
        for (int p = 0; p < NUM_PROCS; p++)
        begin
            if (m_val[p] && (off_reg[p] != m_off[p]))
            begin
                leq = 1'b0;
            end
            if (m_val[p] && (mfield[p] != m_off[p]))
            begin
                meq = 1'b0;
            end
        end

        count_max = (count_reg > item_reg.msg_count) ? count_reg : item_reg.msg_count;
        own_oo    = vmap_reg[own_idx] ? off_reg[own_idx] : eps_lim;
        oo_le     = (32'(own_oo) <= noff);
        send_same = (time_reg >= item_reg.phys_time);

        time_next  = time_reg;
        vmap_next  = vmap_reg;
        off_next   = off_reg;
        count_next = count_reg;

        unique case (item_reg.kind)
            KIND_SEND:
            begin
                priority if (send_same && oo_le)
                begin
                    count_next = sat_inc(count_reg);
                end
                else if (send_same)
                begin
                    off_next[own_idx]  = noff[OB-1:0];
                    vmap_next[own_idx] = 1'b1;
                    count_next         = '0;
                end
                else
                begin
                    time_next          = nt_send;
                    vmap_next          = a_val;
                    off_next           = a_off;
                    off_next[own_idx]  = '0;
                    vmap_next[own_idx] = 1'b1;
                    count_next         = '0;
                end
            end
            KIND_RECEIVE:
            begin
                time_next          = nt_recv;
                vmap_next          = m_val;
                vmap_next[own_idx] = 1'b1;
                off_next           = m_off;
                priority if (leq && meq)
                begin
                    count_next = sat_inc(count_max);
                end
                else if (leq)
                begin
                    count_next = sat_inc(count_reg);
                end
                else if (meq)
                begin
                    count_next = sat_inc(item_reg.msg_count);
                end
                else
                begin
                    count_next = '0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        packed_off = '0;
        for (int p = 0; p < NUM_PROCS; p++)
        begin
            if (vmap_next[p])
            begin
                packed_off[p*OB +: OB] = off_next[p];
            end
        end
        vm_ext                 = VM_W'(vmap_next);
        out_next.clock_time    = time_next;
        out_next.clock_valid   = vm_ext[15:0];
        out_next.clock_offsets = packed_off[63:0];
        out_next.clock_count   = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_process_reg <= OWN_PROCESS_RESET;
            epsilon_reg     <= EPSILON_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            time_reg        <= '0;
            vmap_reg        <= '0;
            count_reg       <= '0;
            for (int p = 0; p < NUM_PROCS; p++)
            begin
                off_reg[p] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (paddr[APB_ADDR_W-1])
                    REG_OWN_PROCESS: own_process_reg <= pwdata[3:0];
                    REG_EPSILON:     epsilon_reg     <= pwdata[3:0];
                    default:         epsilon_reg     <= epsilon_reg;
                endcase
            end
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= fire;
            end
            if (fire)
            begin
                time_reg  <= time_next;
                vmap_reg  <= vmap_next;
                count_reg <= count_next;
                off_reg   <= off_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_data;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: tb/rct_clock_checker.sv
`timescale 1ns / 1ps
// Checker for the replay clock unit: predicts every result from the accepted items and compares.
module rct_clock_checker
    import rct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_item_t             out_data,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int NP = NUM_PROCS_DEF;
    localparam int OB = OFFSET_BITS_DEF;

    logic [3:0]            own_reg;
    logic [3:0]            eps_reg;
    logic [31:0]           clk_time;
    logic [NP-1:0]         clk_valid;
    logic [NP-1:0][OB-1:0] clk_offs;
    logic [31:0]           clk_count;
    out_item_t             clock_q[$];
    out_item_t             want;

    function automatic logic [OB-1:0] offset_limit();
        int lim;
        lim = (1 << OB) - 1;
        return (int'(eps_reg) < lim) ? eps_reg[OB-1:0] : lim[OB-1:0];
    endfunction

    function automatic logic [31:0] count_up(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Moves a clock forward in time; offsets that reach the limit are dropped.
    function automatic void advance_offsets(input logic [31:0] from_t, input logic [31:0] to_t,
                                            inout logic [NP-1:0] vm,
                                            inout logic [NP-1:0][OB-1:0] off);
        logic [32:0]   d;
        logic [OB-1:0] lim;
        lim = offset_limit();
        for (int p = 0; p < NP; p++) begin
            if (vm[p]) begin
                d = {1'b0, to_t - from_t} + 33'(off[p]);
                if (d >= 33'(lim)) begin
                    vm[p]  = 1'b0;
                    off[p] = '0;
                end else begin
                    off[p] = d[OB-1:0];
                end
            end
        end
    endfunction

    function automatic out_item_t apply_event(input in_item_t ev);
        logic [OB-1:0]         lim;
        logic [3:0]            own;
        logic [31:0]           nt;
        logic [31:0]           noff;
        logic [OB-1:0]         own_off;
        logic [NP-1:0]         av;
        logic [NP-1:0]         bv;
        logic [NP-1:0][OB-1:0] aoff;
        logic [NP-1:0][OB-1:0] boff;
        logic [OB-1:0]         x;
        logic [OB-1:0]         y;
        logic [OB-1:0]         m;
        logic                  leq;
        logic                  meq;
        out_item_t             res;
        lim = offset_limit();
        own = own_reg;
        if (ev.kind == KIND_SEND) begin
            nt = (clk_time > ev.phys_time) ? clk_time : ev.phys_time;
            noff = nt - ev.phys_time;
            own_off = clk_valid[own] ? clk_offs[own] : lim;
            if (nt == clk_time && 32'(own_off) <= noff) begin
                clk_count = count_up(clk_count);
            end else if (nt == clk_time) begin
                clk_offs[own]  = noff[OB-1:0];
                clk_valid[own] = 1'b1;
                clk_count      = '0;
            end else begin
                advance_offsets(clk_time, nt, clk_valid, clk_offs);
                clk_time       = nt;
                clk_offs[own]  = '0;
                clk_valid[own] = 1'b1;
                clk_count      = '0;
            end
        end else begin
            nt = (clk_time > ev.msg_time) ? clk_time : ev.msg_time;
            if (ev.phys_time > nt)
                nt = ev.phys_time;
            av   = clk_valid;
            bv   = ev.msg_valid;
            aoff = clk_offs;
            for (int p = 0; p < NP; p++)
                boff[p] = bv[p] ? ev.msg_offsets[p*OB +: OB] : '0;
            advance_offsets(clk_time, nt, av, aoff);
            advance_offsets(ev.msg_time, nt, bv, boff);
            av = av | bv;
            for (int p = 0; p < NP; p++) begin
                if (av[p]) begin
                    x = aoff[p];
                    y = bv[p] ? boff[p] : lim;
                    m = (x < y) ? x : y;
                    if (m >= lim) begin
                        av[p]   = 1'b0;
                        aoff[p] = '0;
                    end else begin
                        aoff[p] = m;
                    end
                end else begin
                    aoff[p] = '0;
                end
            end
            leq = (clk_time == nt) && (clk_valid == av);
            meq = (ev.msg_time == nt) && (ev.msg_valid == av);
            for (int p = 0; p < NP; p++) begin
                if (av[p]) begin
                    if (clk_offs[p] != aoff[p])
                        leq = 1'b0;
                    if (ev.msg_offsets[p*OB +: OB] != aoff[p])
                        meq = 1'b0;
                end
            end
            if (leq && meq)
                clk_count = count_up((clk_count > ev.msg_count) ? clk_count : ev.msg_count);
            else if (leq)
                clk_count = count_up(clk_count);
            else if (meq)
                clk_count = count_up(ev.msg_count);
            else
                clk_count = '0;
            clk_time       = nt;
            clk_valid      = av;
            clk_valid[own] = 1'b1;
            clk_offs       = aoff;
        end
        res.clock_time    = clk_time;
        res.clock_valid   = clk_valid;
        res.clock_offsets = '0;
        for (int p = 0; p < NP; p++)
            if (clk_valid[p])
                res.clock_offsets[p*OB +: OB] = clk_offs[p];
        res.clock_count   = clk_count;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            own_reg     = OWN_PROCESS_RESET;
            eps_reg     = EPSILON_RESET;
            clk_time    = '0;
            clk_valid   = '0;
            clk_offs    = '0;
            clk_count   = '0;
            mismatches  = 0;
            outstanding = 0;
            clock_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_OWN_PROCESS)
                    own_reg = pwdata[3:0];
                else
                    eps_reg = pwdata[3:0];
            end
            if (in_valid && !in_stall)
                clock_q.push_back(apply_event(in_data));
            if (out_valid && !out_stall) begin
                if (clock_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got %h", $time, out_data);
                end else begin
                    want = clock_q.pop_front();
                    if (out_data.clock_time !== want.clock_time) begin
                        mismatches++;
                        $display("%0t: clock_time expected %h, got %h",
                                 $time, want.clock_time, out_data.clock_time);
                    end
                    if (out_data.clock_valid !== want.clock_valid) begin
                        mismatches++;
                        $display("%0t: clock_valid expected %h, got %h",
                                 $time, want.clock_valid, out_data.clock_valid);
                    end
                    if (out_data.clock_offsets !== want.clock_offsets) begin
                        mismatches++;
                        $display("%0t: clock_offsets expected %h, got %h",
                                 $time, want.clock_offsets, out_data.clock_offsets);
                    end
                    if (out_data.clock_count !== want.clock_count) begin
                        mismatches++;
                        $display("%0t: clock_count expected %h, got %h",
                                 $time, want.clock_count, out_data.clock_count);
                    end
                end
            end
            outstanding = clock_q.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the replay clock unit: clock, reset, stimulus, flow control and verdict.
module tb_top;
    import rct_pkg::*;

    localparam int OB          = OFFSET_BITS_DEF;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 180;
    localparam logic [4:0][3:0] OWN_SET = {4'd12, 4'd9, 4'd15, 4'd5, 4'd0};
    localparam logic [4:0][3:0] EPS_SET = {4'd7, 4'd0, 4'd1, 4'd3, 4'd15};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    int                    mismatches;
    int                    outstanding;
    int                    sent_cnt;
    int                    rcvd_cnt;
    out_item_t             last_out;
    logic                  hold_req;
    logic [31:0]           tbase;

    replay_clock_timestamp_unit_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    rct_clock_checker clock_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a - b : 32'd0;
    endfunction

    function automatic logic [63:0] rand_offsets(input int maxv);
        logic [63:0] v;
        for (int p = 0; p < 64 / OB; p++)
            v[p*OB +: OB] = OB'($urandom_range(0, maxv));
        return v;
    endfunction

    function automatic logic [31:0] pick_count(input logic [31:0] base);
        case ($urandom_range(0, 4))
            0:       return base;
            1:       return 32'd0;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'hFFFF_FFFE;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t send_event(input logic [31:0] pt);
        in_item_t ev;
        ev.kind        = KIND_SEND;
        ev.phys_time   = pt;
        ev.msg_time    = $urandom;
        ev.msg_valid   = 16'($urandom);
        ev.msg_offsets = {$urandom, $urandom};
        ev.msg_count   = $urandom;
        return ev;
    endfunction

    function automatic in_item_t recv_event(input logic [31:0] pt, input logic [31:0] mt,
                                            input logic [15:0] mv, input logic [63:0] mo,
                                            input logic [31:0] mc);
        in_item_t ev;
        ev.kind        = KIND_RECEIVE;
        ev.phys_time   = pt;
        ev.msg_time    = mt;
        ev.msg_valid   = mv;
        ev.msg_offsets = mo;
        ev.msg_count   = mc;
        return ev;
    endfunction

    task automatic push(input in_item_t ev);
        in_data  <= ev;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sent_cnt++;
        if (ev.phys_time > tbase)
            tbase = ev.phys_time;
        if (ev.kind == KIND_RECEIVE && ev.msg_time > tbase)
            tbase = ev.msg_time;
    endtask

    task automatic pause(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sent_cnt != rcvd_cnt);
    endtask

    // Sends back the clock just produced, so both sides of a merge can be equal.
    task automatic push_echo(input bit tweak);
        in_item_t ev;
        drain();
        ev = recv_event(sat_sub(last_out.clock_time, $urandom_range(0, 3)),
                        last_out.clock_time, last_out.clock_valid, last_out.clock_offsets,
                        pick_count(last_out.clock_count));
        if (tweak) begin
            if ($urandom_range(0, 1))
                ev.msg_offsets[$urandom_range(0, 63)] ^= 1'b1;
            else
                ev.msg_valid[$urandom_range(0, 15)] ^= 1'b1;
        end
        push(ev);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic directed_items();
        in_item_t ev;
        push(send_event(32'd0));
        push(send_event(32'd0));
        push(send_event(32'd10));
        push(send_event(32'd3));
        push(recv_event(32'd0, 32'd20, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        push(recv_event(32'd5, 32'd2, 16'hFFFF, 64'h0123_4567_89AB_CDEF, 32'd5));
        push(recv_event(32'd0, 32'd0, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0));
        push_echo(1'b0);
        push_echo(1'b0);
        push_echo(1'b1);
        push(recv_event(32'd100, 32'd40, 16'hA5A5, 64'd0, 32'hFFFF_FFFE));
        push(recv_event(32'd101, 32'd101, 16'h5A5A, 64'd0, 32'd7));
        push(send_event(32'd90));
        push(send_event(32'd111));
        ev      = '1;
        ev.kind = KIND_SEND;
        ev.phys_time = 32'd120;
        push(ev);
        ev      = '0;
        ev.kind = KIND_RECEIVE;
        push(ev);
        push_echo(1'b0);
    endtask

    task automatic run_phase(input int n, input bit with_hold);
        in_item_t    ev;
        logic [31:0] mt;
        int          r;
        bit          calm;
        bit          idle_on;
        idle_on = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (i % 32 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            calm = with_hold && i < 60;
            if (with_hold && i == 0)
                hold_req <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 25) begin
                push(send_event(sat_sub(tbase, $urandom_range(0, 8))));
            end else if (r < 40) begin
                push(send_event(sat_add(tbase, $urandom_range(0, 3))));
            end else if (r < 52) begin
                mt = sat_add(sat_sub(tbase, $urandom_range(0, 16)), $urandom_range(0, 4));
                push(recv_event(sat_sub(tbase, $urandom_range(0, 4)), mt, 16'($urandom),
                                rand_offsets($urandom_range(0, 15)), $urandom));
            end else if (r < 60) begin
                push(recv_event(sat_sub(tbase, $urandom_range(0, 3)),
                                sat_sub(tbase, $urandom_range(0, 20)), 16'h0000,
                                {$urandom, $urandom}, $urandom));
            end else if (r < 72 && !calm) begin
                push_echo($urandom_range(0, 3) == 0);
            end else if (r < 82) begin
                mt = sat_add(tbase, $urandom_range(1, 40));
                push(recv_event(sat_sub(mt, $urandom_range(0, 5)), mt, 16'($urandom),
                                $urandom_range(0, 1) ? 64'd0 : rand_offsets($urandom_range(0, 4)),
                                pick_count($urandom)));
            end else if (r < 92) begin
                push(recv_event(last_out.clock_time, last_out.clock_time,
                                last_out.clock_valid & 16'($urandom), last_out.clock_offsets,
                                pick_count(last_out.clock_count)));
            end else begin
                ev = recv_event(sat_add(tbase, $urandom_range(0, 1000)),
                                sat_add(tbase, $urandom_range(0, 1000)), 16'($urandom),
                                {$urandom, $urandom}, $urandom);
                ev.kind = 1'($urandom);
                push(ev);
            end
            if (!calm && idle_on && $urandom_range(0, 99) < 35)
                pause(($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3));
        end
    endtask

    initial begin
        logic [3:0] own_v;
        logic [3:0] eps_v;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        in_data  <= '0;
        hold_req <= 1'b0;
        sent_cnt = 0;
        tbase    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            repeat (4) @(posedge clk);
            if (ph < 5) begin
                own_v = OWN_SET[ph];
                eps_v = EPS_SET[ph];
            end else begin
                own_v = 4'($urandom);
                eps_v = 4'($urandom);
            end
            write_reg(REG_OWN_PROCESS, own_v);
            write_reg(REG_EPSILON, eps_v);
            tbase = sat_add(tbase, $urandom_range(0, 1 << 16));
            run_phase(PHASE_ITEMS, ph == 2);
        end
        drain();
        repeat (4) @(posedge clk);
        write_reg(REG_OWN_PROCESS, 4'd3);
        write_reg(REG_EPSILON, 4'd15);
        tbase = 32'hFFFF_FF00;
        run_phase(50, 1'b0);
        push(send_event(32'hFFFF_FFFF));
        push(recv_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 64'd0, 32'hFFFF_FFFF));
        push_echo(1'b0);
        push(recv_event(32'd0, 32'd0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0));
        push(send_event(32'hFFFF_FFFF));
        drain();
        repeat (6) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        int stall_pct;
        int cyc;
        bit held;
        out_stall <= 1'b0;
        rcvd_cnt  <= 0;
        last_out  <= '0;
        stall_pct = 0;
        cyc       = 0;
        held      = 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                rcvd_cnt <= rcvd_cnt + 1;
                last_out <= out_data;
            end
            cyc++;
            if (cyc % 64 == 0)
                stall_pct = $urandom_range(0, 1) ? 0 : $urandom_range(10, 85);
            if (hold_req && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 199) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 30)) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rct_pkg.sv
rtl/replay_clock_timestamp_unit_core.sv
tb/rct_clock_checker.sv
tb/tb_top.sv
